// ===== rtl/core/u8cp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package u8cp_pkg;

  // Class of a byte when it stands at the front of the window.
  typedef enum logic [2:0] {
    CLS_ASCII   = 3'd0,
    CLS_LEAD2   = 3'd1,
    CLS_LEAD3   = 3'd2,
    CLS_LEAD4   = 3'd3,
    CLS_INVALID = 3'd4
  } cls_t;

  // One queued byte with its end-of-text flag and its class.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cls_t       cls;
  } q_item_t;

  localparam logic [7:0]  LEAD2_MASK = 8'hE0;
  localparam logic [7:0]  LEAD2_TAG  = 8'hC0;
  localparam logic [7:0]  LEAD3_MASK = 8'hF0;
  localparam logic [7:0]  LEAD3_TAG  = 8'hE0;
  localparam logic [7:0]  LEAD4_MASK = 8'hF8;
  localparam logic [7:0]  LEAD4_TAG  = 8'hF0;
  localparam logic [1:0]  CONT_TAG   = 2'b10;

  localparam logic [20:0] REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [20:0] MAX_CP         = 21'h10FFFF;
  localparam logic [20:0] SURR_LO        = 21'h00D800;
  localparam logic [20:0] SURR_HI        = 21'h00DFFF;
  localparam logic [20:0] MIN_CP2        = 21'h000080;
  localparam logic [20:0] MIN_CP3        = 21'h000800;
  localparam logic [20:0] MIN_CP4        = 21'h010000;

  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    if (!b[7]) begin
      c = CLS_ASCII;
    end else if ((b & LEAD2_MASK) == LEAD2_TAG) begin
      c = CLS_LEAD2;
    end else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
      c = CLS_LEAD3;
    end else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
      c = CLS_LEAD4;
    end else begin
      c = CLS_INVALID;
    end
    return c;
  endfunction

  // Number of continuation bytes that a lead needs; zero for single bytes.
  function automatic logic [1:0] cont_count(input cls_t c);
    logic [1:0] n;
    unique case (c)
      CLS_LEAD2: n = 2'd1;
      CLS_LEAD3: n = 2'd2;
      CLS_LEAD4: n = 2'd3;
      default:   n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/u8cp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface u8cp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

interface u8cp_out_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic        replaced;
  logic        run_last;
  logic        text_done;

  modport source (output valid, output code_point, output replaced, output run_last,
                  output text_done, input ready);
  modport sink   (input valid, input code_point, input replaced, input run_last,
                  input text_done, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/u8cp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8cp_front
  import u8cp_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  u8cp_in_if.sink      in_ch,
  output q_item_t      q_item,
  output logic         q_valid,
  input  wire logic    q_pop
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_item_t         mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            push, pop;

  assign in_ch.ready = (count_r != CW'(DEPTH));
  assign q_valid     = (count_r != '0);
  assign q_item      = mem_r[rd_ptr_r];

  assign push = in_ch.valid && in_ch.ready;
  assign pop  = q_pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // The class is worked out on entry so the back end sees it ready-made.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{data: in_ch.in_byte, last: in_ch.text_end,
                           cls: classify(in_ch.in_byte)};
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8cp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8cp_back
  import u8cp_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  q_item_t   q_item,
  input  wire logic q_valid,
  output logic      q_pop,
  u8cp_out_if.source out_ch
);

  logic [7:0]  win_byte_r [4];
  cls_t        win_cls_r  [4];
  logic [2:0]  fill_r;
  logic        end_r;
  logic        busy_r;

  logic        out_valid_r;
  logic [20:0] cp_r;
  logic        rep_r, last_r, done_r;

  logic        slot_free, step;
  logic [7:0]  vb [4];
  cls_t        vc [4];
  logic [2:0]  fill_v;
  logic        end_v;
  logic [1:0]  cc;
  logic [1:0]  cc_next;
  logic [2:0]  need;
  logic [2:0]  need_next;
  logic [3:1]  cont_ok;
  logic [20:0] cp2, cp3, cp4;
  logic        ok2, ok3, ok4;
  logic        have_res, res_rep;
  logic [20:0] res_cp;
  logic [2:0]  drop;
  logic [2:0]  rem_fill;
  logic [2:0]  sel;
  logic [7:0]  nb [4];
  cls_t        nc [4];
  logic        next_lead, more;

  assign slot_free = !out_valid_r || out_ch.ready;
  assign step      = slot_free && (busy_r || q_valid);
  // A new byte is taken only once the previous one has been fully scanned.
  assign q_pop     = slot_free && !busy_r && q_valid;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      if (!busy_r && fill_r == 3'(i)) begin
        vb[i] = q_item.data;
        vc[i] = q_item.cls;
      end else begin
        vb[i] = win_byte_r[i];
        vc[i] = win_cls_r[i];
      end
    end
    fill_v = busy_r ? fill_r : fill_r + 3'd1;
    end_v  = busy_r ? end_r : q_item.last;

    cc   = cont_count(vc[0]);
    need = {1'b0, cc} + 3'd1;
    for (int i = 1; i < 4; i++) begin
      cont_ok[i] = (vb[i][7:6] == CONT_TAG);
    end

    cp2 = {10'd0, vb[0][4:0], vb[1][5:0]};
    cp3 = {5'd0, vb[0][3:0], vb[1][5:0], vb[2][5:0]};
    cp4 = {vb[0][2:0], vb[1][5:0], vb[2][5:0], vb[3][5:0]};
    ok2 = cont_ok[1] && (cp2 >= MIN_CP2);
    ok3 = cont_ok[1] && cont_ok[2] && (cp3 >= MIN_CP3) &&
          !((cp3 >= SURR_LO) && (cp3 <= SURR_HI));
    ok4 = cont_ok[1] && cont_ok[2] && cont_ok[3] && (cp4 >= MIN_CP4) && (cp4 <= MAX_CP);

    have_res = 1'b0;
    res_rep  = 1'b0;
    res_cp   = REPLACEMENT_CP;
    drop     = 3'd0;
    unique case (vc[0]) inside
      CLS_ASCII: begin
        have_res = 1'b1;
        res_cp   = {13'd0, vb[0]};
        drop     = 3'd1;
      end
      CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
        if (fill_v < need) begin
          // A window cut short by the end of the text gives one replacement.
          if (end_v) begin
            have_res = 1'b1;
            res_rep  = 1'b1;
            drop     = fill_v;
          end
        end else begin
          have_res = 1'b1;
          if (vc[0] == CLS_LEAD2 && ok2) begin
            res_cp = cp2;
            drop   = need;
          end else if (vc[0] == CLS_LEAD3 && ok3) begin
            res_cp = cp3;
            drop   = need;
          end else if (vc[0] == CLS_LEAD4 && ok4) begin
            res_cp = cp4;
            drop   = need;
          end else begin
            res_rep = 1'b1;
            drop    = 3'd1;
          end
        end
      end
      default: begin
        have_res = 1'b1;
        res_rep  = 1'b1;
        drop     = 3'd1;
      end
    endcase

    rem_fill = fill_v - drop;
    for (int i = 0; i < 4; i++) begin
      sel = 3'(i) + drop;
      if (sel < 3'd4) begin
        nb[i] = vb[sel[1:0]];
        nc[i] = vc[sel[1:0]];
      end else begin
        nb[i] = vb[i];
        nc[i] = vc[i];
      end
    end

    // Decide now whether the remaining bytes give another result for this byte.
    cc_next   = cont_count(nc[0]);
    need_next = {1'b0, cc_next} + 3'd1;
    next_lead = (nc[0] == CLS_LEAD2) || (nc[0] == CLS_LEAD3) || (nc[0] == CLS_LEAD4);
    more      = have_res && (rem_fill != 3'd0) &&
                (end_v || !(next_lead && rem_fill < need_next));
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int i = 0; i < 4; i++) begin
        win_byte_r[i] <= nb[i];
        win_cls_r[i]  <= nc[i];
      end
    end
    if (slot_free) begin
      cp_r   <= res_cp;
      rep_r  <= res_rep;
      last_r <= !more;
      done_r <= !more && end_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= 3'd0;
      end_r       <= 1'b0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (step) begin
        fill_r <= (end_v && !more) ? 3'd0 : rem_fill;
        end_r  <= end_v;
        busy_r <= more;
      end
      if (slot_free) begin
        out_valid_r <= step && have_res;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.code_point = cp_r;
  assign out_ch.replaced   = rep_r;
  assign out_ch.run_last   = last_r;
  assign out_ch.text_done  = done_r;

endmodule

`default_nettype wire

// ===== rtl/core/utf8_to_codepoint_decoder.sv =====
// Channel   Dir  Handshake          Payload
// in_ch     in   valid / ready      in_byte[7:0], text_end
// out_ch    out  valid / ready      code_point[20:0], replaced, run_last, text_done
//
// A byte enters a small queue and is scanned once the scan unit is idle and the output slot
// is free; its first result is registered at the end of that scan.
// The scan unit gives one result per cycle while the receiver takes them; a byte gives
// up to four results when a failed window forces the buffered bytes to be rescanned.
// Reset is synchronous and active low; it empties the queue and the window.
// Either side may stall on its own; the queue absorbs input while results wait.
`timescale 1ns / 1ps
`default_nettype none

module utf8_to_codepoint_decoder
  import u8cp_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  u8cp_in_if.sink    in_ch,
  u8cp_out_if.source out_ch
);

  q_item_t q_item;
  logic    q_valid;
  logic    q_pop;

  u8cp_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_pop  (q_pop)
  );

  u8cp_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_item (q_item),
    .q_valid(q_valid),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

`default_nettype wire

// ===== rtl/core/u8cp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module u8cp_checker
  import u8cp_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [20:0] code_point,
  input wire logic        replaced,
  input wire logic        run_last,
  input wire logic        text_done
);

  // A stalled result stays put until the transaction completes.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_point) && $stable(replaced))
    else $error("result changed while stalled");

  // The end of a text also ends the run of results of its last byte.
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && text_done |-> run_last)
    else $error("text_done without run_last");

  a_rep_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && replaced |-> code_point == REPLACEMENT_CP)
    else $error("replacement with wrong code point");

  // A decoded value is always a Unicode scalar value.
  a_scalar: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !replaced |->
      code_point <= MAX_CP && (code_point < SURR_LO || code_point > SURR_HI))
    else $error("decoded value is not a scalar value");

endmodule

bind utf8_to_codepoint_decoder u8cp_checker u_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .code_point(out_ch.code_point),
  .replaced  (out_ch.replaced),
  .run_last  (out_ch.run_last),
  .text_done (out_ch.text_done)
);

`default_nettype wire

// ===== verif/utf8_to_codepoint_decoder_tb.sv =====
`timescale 1ns / 1ps

module utf8_to_codepoint_decoder_tb;
  import u8cp_pkg::*;

  localparam int RANDOM_BYTES = 260;
  localparam int CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic [20:0] code_point;
    logic        replaced;
    logic        run_last;
    logic        text_done;
  } cp_result_t;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } text_byte_t;

  // Tracks the decoder's window and holds the code points it must still emit.
  class decode_tracker;
    logic [7:0]  win [4];
    int unsigned fill;
    cp_result_t  expected_cps [$];
    int          errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    function int pending();
      return expected_cps.size();
    endfunction

    task report_mismatch(input string msg);
      errors++;
      if (errors <= 40) $display("ERROR t=%0t: %s", $time, msg);
    endtask

    function void drop_front(int unsigned k);
      if (k >= fill) begin
        fill = 0;
      end else begin
        for (int unsigned i = 0; i + k < fill; i++) win[i] = win[i + k];
        fill = fill - k;
      end
    endfunction

    function void add_cp(logic [20:0] cp, logic rep);
      cp_result_t r;
      r.code_point = cp;
      r.replaced   = rep;
      r.run_last   = 1'b0;
      r.text_done  = 1'b0;
      expected_cps.insert(expected_cps.size(), r);
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      cls_t        lead_cls;
      logic [20:0] cp;
      int unsigned need;
      int          n;
      logic        ok;
      logic        waiting;
      cp_result_t  tail;
      win[fill] = b;
      fill++;
      n = 0;
      waiting = 1'b0;
      while (fill > 0 && !waiting) begin
        if (!win[0][7]) lead_cls = CLS_ASCII;
        else if (win[0][7:5] == 3'b110) lead_cls = CLS_LEAD2;
        else if (win[0][7:4] == 4'b1110) lead_cls = CLS_LEAD3;
        else if (win[0][7:3] == 5'b11110) lead_cls = CLS_LEAD4;
        else lead_cls = CLS_INVALID;
        case (lead_cls)
          CLS_ASCII: begin
            add_cp({14'd0, win[0][6:0]}, 1'b0);
            n++;
            drop_front(1);
          end
          CLS_LEAD2, CLS_LEAD3, CLS_LEAD4: begin
            if (lead_cls == CLS_LEAD2) begin
              need = 1;
              cp = {16'd0, win[0][4:0]};
            end else if (lead_cls == CLS_LEAD3) begin
              need = 2;
              cp = {17'd0, win[0][3:0]};
            end else begin
              need = 3;
              cp = {18'd0, win[0][2:0]};
            end
            if (fill < need + 1) begin
              // A text that stops inside a window loses the whole window.
              if (last) begin
                add_cp(REPLACEMENT_CP, 1'b1);
                n++;
                fill = 0;
              end
              waiting = 1'b1;
            end else begin
              ok = 1'b1;
              for (int unsigned i = 1; i <= need; i++) begin
                if (win[i][7:6] != CONT_TAG) ok = 1'b0;
                else if (ok) cp = (cp << 6) | {15'd0, win[i][5:0]};
              end
              if (ok) begin
                if ((need == 1 && cp < MIN_CP2) || (need == 2 && cp < MIN_CP3) ||
                    (need == 3 && cp < MIN_CP4))
                  ok = 1'b0;
                else if (cp > MAX_CP || (cp >= SURR_LO && cp <= SURR_HI))
                  ok = 1'b0;
              end
              n++;
              if (ok) begin
                add_cp(cp, 1'b0);
                drop_front(need + 1);
              end else begin
                // Only the lead goes; the bytes behind it are scanned again.
                add_cp(REPLACEMENT_CP, 1'b1);
                drop_front(1);
              end
            end
          end
          default: begin
            add_cp(REPLACEMENT_CP, 1'b1);
            n++;
            drop_front(1);
          end
        endcase
      end
      if (last) fill = 0;
      if (n > 0) begin
        tail = expected_cps[expected_cps.size() - 1];
        tail.run_last  = 1'b1;
        tail.text_done = last;
        expected_cps[expected_cps.size() - 1] = tail;
      end
    endfunction

    task check_cp(input logic [20:0] cp, input logic rep, input logic rl, input logic td);
      cp_result_t want;
      if (expected_cps.size() == 0) begin
        report_mismatch($sformatf("unexpected result code_point=%h", cp));
        return;
      end
      want = expected_cps.pop_front();
      if (cp !== want.code_point)
        report_mismatch($sformatf("code_point %h, want %h", cp, want.code_point));
      if (rep !== want.replaced)
        report_mismatch($sformatf("replaced %b, want %b (cp %h)", rep, want.replaced,
                                  want.code_point));
      if (rl !== want.run_last)
        report_mismatch($sformatf("run_last %b, want %b (cp %h)", rl, want.run_last,
                                  want.code_point));
      if (td !== want.text_done)
        report_mismatch($sformatf("text_done %b, want %b (cp %h)", td, want.text_done,
                                  want.code_point));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   rx_mode;
  int   rx_hold;
  int   n_directed;

  decode_tracker tracker;
  text_byte_t    text_bytes [$];
  logic [7:0]    seq [$];

  u8cp_in_if  in_if ();
  u8cp_out_if out_if ();

  utf8_to_codepoint_decoder DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL utf8_to_codepoint_decoder");
      $finish;
    end
  end

  // Accepted transactions on both channels, sampled at the rising edge.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_if.valid && in_if.ready) tracker.note_byte(in_if.in_byte, in_if.text_end);
      if (out_if.valid && out_if.ready)
        tracker.check_cp(out_if.code_point, out_if.replaced, out_if.run_last,
                         out_if.text_done);
    end
  end

  // The receiver switches between steady acceptance and several stall patterns.
  always @(negedge clk) begin
    if (rx_hold == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_hold = $urandom_range(16, 96);
    end
    rx_hold--;
    case (rx_mode)
      0: out_if.ready <= 1'b1;
      1: out_if.ready <= 1'($urandom_range(0, 1));
      2: out_if.ready <= ($urandom_range(0, 3) == 0);
      default: out_if.ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  function automatic void put(logic [7:0] b, logic last);
    text_byte_t item;
    item.value = b;
    item.last  = last;
    text_bytes.insert(text_bytes.size(), item);
  endfunction

  function automatic logic [20:0] rand_cp(int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 'h7F));
      2: cp = 21'($urandom_range('h80, 'h7FF));
      3: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h002000;
      end
      default: cp = 21'($urandom_range('h10000, 'h10FFFF));
    endcase
    return cp;
  endfunction

  // Encodes cp in exactly len bytes, whether or not that is the shortest form.
  function automatic void load_seq(logic [20:0] cp, int len);
    seq.delete();
    case (len)
      1: seq.insert(seq.size(), {1'b0, cp[6:0]});
      2: begin
        seq.insert(seq.size(), {3'b110, cp[10:6]});
        seq.insert(seq.size(), {2'b10, cp[5:0]});
      end
      3: begin
        seq.insert(seq.size(), {4'b1110, cp[15:12]});
        seq.insert(seq.size(), {2'b10, cp[11:6]});
        seq.insert(seq.size(), {2'b10, cp[5:0]});
      end
      default: begin
        seq.insert(seq.size(), {5'b11110, cp[20:18]});
        seq.insert(seq.size(), {2'b10, cp[17:12]});
        seq.insert(seq.size(), {2'b10, cp[11:6]});
        seq.insert(seq.size(), {2'b10, cp[5:0]});
      end
    endcase
  endfunction

  function automatic void emit_seq();
    logic last;
    foreach (seq[i]) begin
      last = ($urandom_range(0, 39) == 0) ||
             (i == seq.size() - 1 && $urandom_range(0, 9) == 0);
      put(seq[i], last);
    end
  endfunction

  function automatic void build_random();
    int          pick;
    int          len;
    int          keep;
    logic [20:0] cp;
    while (text_bytes.size() < n_directed + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      len = $urandom_range(1, 4);
      if (pick < 55) begin
        load_seq(rand_cp(len), len);
      end else if (pick < 63) begin
        len = $urandom_range(2, 4);
        case (len)
          2: cp = 21'($urandom_range(0, 'h7F));
          3: cp = 21'($urandom_range(0, 'h7FF));
          default: cp = 21'($urandom_range(0, 'hFFFF));
        endcase
        load_seq(cp, len);
      end else if (pick < 69) begin
        load_seq(21'($urandom_range(SURR_LO, SURR_HI)), 3);
      end else if (pick < 75) begin
        load_seq(21'($urandom_range('h110000, 'h1FFFFF)), 4);
      end else if (pick < 87) begin
        len = $urandom_range(2, 4);
        load_seq(rand_cp(len), len);
        if ($urandom_range(0, 1)) begin
          seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
        end else begin
          keep = $urandom_range(1, len - 1);
          while (seq.size() > keep) seq.delete(seq.size() - 1);
        end
      end else begin
        seq.delete();
        repeat ($urandom_range(1, 3)) seq.insert(seq.size(), 8'($urandom_range(0, 255)));
      end
      emit_seq();
    end
  endfunction

  task automatic drive_text();
    int burst;
    int gap;
    burst = 0;
    for (int i = 0; i < text_bytes.size(); i++) begin
      if (i == n_directed || (i > n_directed && $urandom_range(0, 63) == 0)) begin
        // Hold off until the decoder has drained every pending code point.
        in_if.valid <= 1'b0;
        @(negedge clk);
        while (tracker.pending() != 0) @(negedge clk);
      end else if (burst == 0) begin
        burst = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
      if (burst > 0) burst--;
      in_if.valid    <= 1'b1;
      in_if.in_byte  <= text_bytes[i].value;
      in_if.text_end <= text_bytes[i].last;
      do @(posedge clk); while (!in_if.ready);
      @(negedge clk);
    end
    in_if.valid <= 1'b0;
  endtask

  initial begin
    tracker = new();
    clk = 1'b0;
    rst_n = 1'b0;
    cycle_count = 0;
    rx_mode = 0;
    rx_hold = 0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.text_end = 1'b0;
    out_if.ready = 1'b0;

    // ASCII extremes, with a text ending on a single byte.
    put(8'h00, 1'b0); put(8'h7F, 1'b1);
    // Shortest two byte form, then an overlong two byte form.
    put(8'hC2, 1'b0); put(8'h80, 1'b0);
    put(8'hC1, 1'b0); put(8'hBF, 1'b0);
    // Largest three byte value, then a surrogate that forces a rescan.
    put(8'hEF, 1'b0); put(8'hBF, 1'b0); put(8'hBF, 1'b0);
    put(8'hED, 1'b0); put(8'hA0, 1'b0); put(8'h80, 1'b0);
    // Highest scalar value, then one step past it.
    put(8'hF4, 1'b0); put(8'h8F, 1'b0); put(8'hBF, 1'b0); put(8'hBF, 1'b0);
    put(8'hF4, 1'b0); put(8'h90, 1'b0); put(8'h80, 1'b0); put(8'h80, 1'b0);
    // A window with a bad continuation byte, an invalid lead, and a text cut short.
    put(8'hE2, 1'b0); put(8'h41, 1'b0); put(8'h42, 1'b0);
    put(8'hFF, 1'b0);
    put(8'hE2, 1'b0); put(8'h82, 1'b1);
    n_directed = text_bytes.size();
    build_random();

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    drive_text();
    while (tracker.pending() != 0) @(negedge clk);
    repeat (16) @(negedge clk);

    if (tracker.errors == 0) begin
      $display("PASS utf8_to_codepoint_decoder");
    end else begin
      $display("FAIL utf8_to_codepoint_decoder");
    end
    $finish;
  end

endmodule
